// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/spat_pkg.sv =====
// Package with widths, codes and defaults of the address translate core
`timescale 1ns / 1ps
package spat_pkg;
  localparam int DESC_DEPTH_DEF = 1024;
  localparam int PAGE_DEPTH_DEF = 1024;
  localparam int DIR_DEPTH      = 1024;
  localparam int DIR_AW         = 10;

  localparam int OP_W      = 3;
  localparam int EIDX_W    = 10;
  localparam int VAL_W     = 64;
  localparam int ADDR_W    = 32;
  localparam int SEL_W     = 16;
  localparam int SEL_IDX_W = 13;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam int PAGE_W    = 21;
  localparam int FRAME_W   = 20;

  localparam int DESC_PRESENT_BIT = 47;
  localparam int SEL_LOCAL_BIT    = 2;

  localparam logic [OP_W-1:0] OP_TRANSLATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_GLOBAL = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_LOCAL  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_DIR    = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD_PAGE   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NULL_GLOBAL = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BEYOND      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_SEG_ABSENT  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DIR_RANGE   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_TBL_RANGE   = 3'd5;
  localparam logic [STAT_W-1:0] STAT_DIR_ABSENT  = 3'd6;
  localparam logic [STAT_W-1:0] STAT_PAGE_ABSENT = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_COUNT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_COUNT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 4'd3;
endpackage

// ===== hdl/spat_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module spat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/spat_alu.sv =====
// Shared 32-bit add and compare unit of the translate sequencer
`timescale 1ns / 1ps
module spat_alu (
  input  logic                       sub,
  input  logic [spat_pkg::ADDR_W-1:0] a,
  input  logic [spat_pkg::ADDR_W-1:0] b,
  output logic [spat_pkg::ADDR_W-1:0] sum,
  output logic                       ge
);
  logic [spat_pkg::ADDR_W:0] res;

  assign res = {1'b0, a} + {1'b0, b ^ {spat_pkg::ADDR_W{sub}}}
             + {{spat_pkg::ADDR_W{1'b0}}, sub};
  assign sum = res[spat_pkg::ADDR_W-1:0];
  assign ge  = res[spat_pkg::ADDR_W];
endmodule

// ===== hdl/segmented_paged_address_translate_core.sv =====
// Top level of the segmented and paged address translate core
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A load request (ops 1 to 4) writes one table entry and leaves the block idle;
// loads beyond a table's depth and ops 5 to 7 are dropped with no result. A translate
// request that passes the index, segment and directory range checks steps through
// descriptor read, index check, segment check and base add, directory range check,
// table range check with the present bits, and the result register. A null selector,
// an index beyond the count or an absent segment goes straight to the result stage.
// While the output register still holds an unaccepted result, a finished translate
// waits in the result stage and the input stays stalled. One shared 32-bit adder
// performs the index compare, the base add and the two range compares in turn, and the
// descriptor, directory and page memories each have one registered read port, so the
// directory and page reads wait for the linear address. The first failing check sets
// the status; the physical address is zero unless the status is ok. A finished result
// waits in the output register while the next request is taken. Table memories are
// not cleared by reset: an entry never loaded reads as unknown. Count registers reset
// to zero and are written only while the block is idle.
module segmented_paged_address_translate_core #(
  parameter int DESC_DEPTH = spat_pkg::DESC_DEPTH_DEF,
  parameter int PAGE_DEPTH = spat_pkg::PAGE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spat_pkg::OP_W-1:0]      op,
  input  logic [spat_pkg::EIDX_W-1:0]    entry_index,
  input  logic [spat_pkg::VAL_W-1:0]     entry_value,
  input  logic [spat_pkg::ADDR_W-1:0]    seg_offset,
  input  logic [spat_pkg::SEL_W-1:0]     segment_selector,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spat_pkg::STAT_W-1:0]    status,
  output logic [spat_pkg::ADDR_W-1:0]    phys_addr,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spat_pkg::CNT_W-1:0]     cfg_data
);
  localparam int DESC_AW = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
  localparam int PAGE_AW = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_SEG,
    ST_DIR,
    ST_TBL,
    ST_DONE
  } state_t;

  state_t state;

  logic [spat_pkg::CNT_W-1:0]     global_count;
  logic [spat_pkg::CNT_W-1:0]     local_count;
  logic [spat_pkg::CNT_W-1:0]     directory_count;
  logic [spat_pkg::CNT_W-1:0]     page_table_count;

  logic                           use_local;
  logic [spat_pkg::SEL_IDX_W-1:0] sel_idx;
  logic [spat_pkg::ADDR_W-1:0]    logical;
  logic [spat_pkg::ADDR_W-1:0]    linear;
  logic [spat_pkg::STAT_W-1:0]    stat;
  logic [spat_pkg::FRAME_W-1:0]   frame;

  logic                           in_acc;
  logic                           trans_acc;
  logic                           g_we;
  logic                           l_we;
  logic                           d_we;
  logic                           p_we;
  logic                           dp_re;
  logic [spat_pkg::VAL_W-1:0]     g_rdata;
  logic [spat_pkg::VAL_W-1:0]     l_rdata;
  logic [spat_pkg::VAL_W-1:0]     desc;
  logic                           d_rdata;
  logic [spat_pkg::PAGE_W-1:0]    p_rdata;
  logic [spat_pkg::SEL_IDX_W-1:0] in_sel_idx;
  logic [spat_pkg::DIR_AW-1:0]    dir_idx;
  logic [spat_pkg::DIR_AW-1:0]    tbl_idx;
  logic                           idx_over;
  logic                           tbl_over;

  logic                           alu_sub;
  logic [spat_pkg::ADDR_W-1:0]    alu_a;
  logic [spat_pkg::ADDR_W-1:0]    alu_b;
  logic [spat_pkg::ADDR_W-1:0]    alu_sum;
  logic                           alu_ge;

  assign in_stall   = (state != ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign trans_acc  = in_acc && (op == spat_pkg::OP_TRANSLATE);
  assign in_sel_idx = segment_selector[spat_pkg::SEL_W-1:3];
  assign g_we = in_acc && (op == spat_pkg::OP_LOAD_GLOBAL)
             && (32'(entry_index) < 32'(DESC_DEPTH));
  assign l_we = in_acc && (op == spat_pkg::OP_LOAD_LOCAL)
             && (32'(entry_index) < 32'(DESC_DEPTH));
  assign d_we = in_acc && (op == spat_pkg::OP_LOAD_DIR);
  assign p_we = in_acc && (op == spat_pkg::OP_LOAD_PAGE)
             && (32'(entry_index) < 32'(PAGE_DEPTH));
  assign dp_re    = (state == ST_DIR);
  assign dir_idx  = linear[31:22];
  assign tbl_idx  = linear[21:12];
  assign desc     = use_local ? l_rdata : g_rdata;
  assign idx_over = (32'(sel_idx) >= 32'(DESC_DEPTH));
  assign tbl_over = (32'(tbl_idx) >= 32'(PAGE_DEPTH));

  spat_ram #(.WIDTH(spat_pkg::VAL_W), .DEPTH(DESC_DEPTH)) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (DESC_AW'(entry_index)),
    .wdata (entry_value),
    .re    (trans_acc),
    .raddr (DESC_AW'(in_sel_idx)),
    .rdata (g_rdata)
  );

  spat_ram #(.WIDTH(spat_pkg::VAL_W), .DEPTH(DESC_DEPTH)) u_local_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (DESC_AW'(entry_index)),
    .wdata (entry_value),
    .re    (trans_acc),
    .raddr (DESC_AW'(in_sel_idx)),
    .rdata (l_rdata)
  );

  spat_ram #(.WIDTH(1), .DEPTH(spat_pkg::DIR_DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (entry_index),
    .wdata (entry_value[0]),
    .re    (dp_re),
    .raddr (dir_idx),
    .rdata (d_rdata)
  );

  spat_ram #(.WIDTH(spat_pkg::PAGE_W), .DEPTH(PAGE_DEPTH)) u_page_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (PAGE_AW'(entry_index)),
    .wdata ({entry_value[31:12], entry_value[0]}),
    .re    (dp_re),
    .raddr (PAGE_AW'(tbl_idx)),
    .rdata (p_rdata)
  );

  spat_alu u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .ge  (alu_ge)
  );

  always_comb begin
    alu_sub = 1'b0;
    alu_a   = '0;
    alu_b   = '0;
    unique case (state)
      ST_IDX: begin
        alu_sub = 1'b1;
        alu_a   = 32'(sel_idx);
        alu_b   = 32'(use_local ? local_count : global_count);
      end
      ST_SEG: begin
        alu_a = {desc[63:56], desc[39:16]};
        alu_b = logical;
      end
      ST_DIR: begin
        alu_sub = 1'b1;
        alu_a   = 32'(dir_idx);
        alu_b   = 32'(directory_count);
      end
      ST_TBL: begin
        alu_sub = 1'b1;
        alu_a   = 32'(tbl_idx);
        alu_b   = 32'(page_table_count);
      end
      ST_IDLE, ST_DONE: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      global_count     <= '0;
      local_count      <= '0;
      directory_count  <= '0;
      page_table_count <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          spat_pkg::REG_GLOBAL_COUNT: global_count     <= cfg_data;
          spat_pkg::REG_LOCAL_COUNT:  local_count      <= cfg_data;
          spat_pkg::REG_DIR_COUNT:    directory_count  <= cfg_data;
          spat_pkg::REG_PAGE_COUNT:   page_table_count <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (trans_acc) begin
            use_local <= segment_selector[spat_pkg::SEL_LOCAL_BIT];
            sel_idx   <= in_sel_idx;
            logical   <= seg_offset;
            state     <= ST_IDX;
          end
        end
        ST_IDX: begin
          if (!use_local && (sel_idx == '0)) begin
            stat  <= spat_pkg::STAT_NULL_GLOBAL;
            state <= ST_DONE;
          end else if (alu_ge || idx_over) begin
            stat  <= spat_pkg::STAT_BEYOND;
            state <= ST_DONE;
          end else begin
            state <= ST_SEG;
          end
        end
        ST_SEG: begin
          if (!desc[spat_pkg::DESC_PRESENT_BIT]) begin
            stat  <= spat_pkg::STAT_SEG_ABSENT;
            state <= ST_DONE;
          end else begin
            linear <= alu_sum;
            state  <= ST_DIR;
          end
        end
        ST_DIR: begin
          if (alu_ge) begin
            stat  <= spat_pkg::STAT_DIR_RANGE;
            state <= ST_DONE;
          end else begin
            state <= ST_TBL;
          end
        end
        ST_TBL: begin
          frame <= p_rdata[spat_pkg::PAGE_W-1:1];
          if (alu_ge || tbl_over) begin
            stat <= spat_pkg::STAT_TBL_RANGE;
          end else if (!d_rdata) begin
            stat <= spat_pkg::STAT_DIR_ABSENT;
          end else if (!p_rdata[0]) begin
            stat <= spat_pkg::STAT_PAGE_ABSENT;
          end else begin
            stat <= spat_pkg::STAT_OK;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= stat;
            phys_addr <= (stat == spat_pkg::STAT_OK) ? {frame, linear[11:0]} : '0;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `ASSERT_CLK(a_phys_zero_on_fault, clk, rst, out_valid && (status != spat_pkg::STAT_OK) |-> phys_addr == '0, "physical address not zero on fault")
  `ASSERT_CLK(a_busy_after_translate, clk, rst, in_valid && !in_stall && op == spat_pkg::OP_TRANSLATE |=> in_stall, "request taken during translate")
  `ASSERT_CLK(a_result_from_done, clk, rst, $rose(out_valid) |-> $past(state == ST_DONE), "result raised outside done")
endmodule
